### rtl/normal_matrix_from_euler_scale_unit_defines.svh
// Assertion macros for the normal matrix unit.
// Included by the top level; no other dependencies.
`ifndef NORMAL_MATRIX_FROM_EULER_SCALE_UNIT_DEFINES_SVH
`define NORMAL_MATRIX_FROM_EULER_SCALE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define NMES_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nmes assertion failed");
`define NMES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nmes assertion failed");
`else
`define NMES_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define NMES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/nmes_pkg.sv
// Shared constants, tables and types of the normal matrix unit.
// No dependencies.
package nmes_pkg;

  localparam int OUT_FRAC_BITS = 16;

  localparam int ANG_W   = 16;
  localparam int SCL_W   = 24;
  localparam int TRIG_W  = 16;
  localparam int OUT_W   = 32;

  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;
  localparam int ANG_TO_Z_SH  = 10;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 33;
  localparam int Z_W          = 25;
  localparam int CORDIC_SH    = 16;
  localparam int TRIG_ONE     = 16384;
  localparam int FRONT_LAT    = CORDIC_STEPS + 2;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
    25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
    25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
    25'sd917,     25'sd458,     25'sd229,    25'sd115
  };

  localparam int TRIG_FRAC = 14;
  localparam int RQ_W      = 46;
  localparam int R_W       = 18;
  localparam int M_W       = 27;
  localparam int CP_W      = 2 * M_W;
  localparam int C_SH      = 16;
  localparam int C_W       = 36;
  localparam int CL_W      = 18;
  localparam int CH_W      = C_W - CL_W;
  localparam int DET_W     = 64;

  // Quotient bits: one above the saturation range, one for rounding.
  localparam int QB      = 34;
  localparam int SH1     = OUT_FRAC_BITS + 17;
  localparam int DIV_LAT = QB + 2;
  localparam int BACK_LAT = 9 + DIV_LAT + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Cyclic neighbours for the cofactor terms.
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  typedef struct packed {
    logic signed [SCL_W-1:0] z;
    logic signed [SCL_W-1:0] y;
    logic signed [SCL_W-1:0] x;
  } scale_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_x;
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_y;
    logic signed [TRIG_W-1:0] cos_y;
    logic signed [TRIG_W-1:0] sin_z;
    logic signed [TRIG_W-1:0] cos_z;
    scale_t                   scl;
  } sc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage

### rtl/nmes_cordic.sv
// Angle reduction and pipelined rotation CORDIC for one angle.
// Depends on nmes_pkg.
module nmes_cordic
  import nmes_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [ANG_W-1:0]  angle_i,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  logic signed [17:0]          a_mod, a_fold;
  logic                        flip;
  logic signed [Z_W-1:0]       z_init;
  logic signed [CORDIC_W-1:0]  x_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0]  y_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]       z_q [CORDIC_STEPS+1];
  logic                        f_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0]  x_d [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]  y_d [CORDIC_STEPS];
  logic signed [Z_W-1:0]       z_d [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0]  xr, yr;
  logic signed [TRIG_W-1:0]    xc, yc;
  logic signed [TRIG_W-1:0]    sin_q, cos_q;

  // Reduce to one turn, then fold into the half turn around zero.
  always_comb begin
    a_mod = 18'(angle_i);
    if (a_mod < 0) a_mod = a_mod + 18'(FULL_TURN);
    if (a_mod < 0) a_mod = a_mod + 18'(FULL_TURN);
    if (a_mod >= 18'(FULL_TURN)) a_mod = a_mod - 18'(FULL_TURN);
    flip   = 1'b0;
    a_fold = a_mod;
    if (a_mod > 18'(QUARTER_TURN) && a_mod <= 18'(FULL_TURN - QUARTER_TURN)) begin
      a_fold = a_mod - 18'(HALF_TURN);
      flip   = 1'b1;
    end else if (a_mod > 18'(FULL_TURN - QUARTER_TURN)) begin
      a_fold = a_mod - 18'(FULL_TURN);
    end
    z_init = Z_W'(a_fold) <<< ANG_TO_Z_SH;
  end

  always_comb begin
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (z_q[k] >= 0) begin
        x_d[k] = x_q[k] - (y_q[k] >>> k);
        y_d[k] = y_q[k] + (x_q[k] >>> k);
        z_d[k] = z_q[k] - ATAN_TAB[k];
      end else begin
        x_d[k] = x_q[k] + (y_q[k] >>> k);
        y_d[k] = y_q[k] - (x_q[k] >>> k);
        z_d[k] = z_q[k] + ATAN_TAB[k];
      end
    end
  end

  always_comb begin
    xr = (x_q[CORDIC_STEPS] + CORDIC_W'(1 << (CORDIC_SH - 1))) >>> CORDIC_SH;
    yr = (y_q[CORDIC_STEPS] + CORDIC_W'(1 << (CORDIC_SH - 1))) >>> CORDIC_SH;
    if (xr > CORDIC_W'(TRIG_ONE)) xr = CORDIC_W'(TRIG_ONE);
    if (xr < -CORDIC_W'(TRIG_ONE)) xr = -CORDIC_W'(TRIG_ONE);
    if (yr > CORDIC_W'(TRIG_ONE)) yr = CORDIC_W'(TRIG_ONE);
    if (yr < -CORDIC_W'(TRIG_ONE)) yr = -CORDIC_W'(TRIG_ONE);
    xc = f_q[CORDIC_STEPS] ? -TRIG_W'(xr) : TRIG_W'(xr);
    yc = f_q[CORDIC_STEPS] ? -TRIG_W'(yr) : TRIG_W'(yr);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CORDIC_GAIN;
      y_q[0] <= '0;
      z_q[0] <= z_init;
      f_q[0] <= flip;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        x_q[k+1] <= x_d[k];
        y_q[k+1] <= y_d[k];
        z_q[k+1] <= z_d[k];
        f_q[k+1] <= f_q[k];
      end
      cos_q <= xc;
      sin_q <= yc;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

### rtl/nmes_front.sv
// Front part: accepts items and turns the three angles into sines and cosines.
// Depends on nmes_pkg and nmes_cordic.
module nmes_front
  import nmes_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [ANG_W-1:0] angle_x_i,
  input  logic signed [ANG_W-1:0] angle_y_i,
  input  logic signed [ANG_W-1:0] angle_z_i,
  input  scale_t                  scl_i,
  input  fifo_st_t                fifo_st_i,
  output logic                    push_o,
  output sc_t                     data_o
);

  logic                 en;
  logic [FRONT_LAT-1:0] vld_q;
  scale_t               scl_q [FRONT_LAT];

  // The pipe only halts when its last word cannot enter the queue.
  assign en         = !(vld_q[FRONT_LAT-1] && fifo_st_i.full);
  assign in_stall_o = !en;
  assign push_o     = vld_q[FRONT_LAT-1] && !fifo_st_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[FRONT_LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      scl_q[0] <= scl_i;
      for (int k = 1; k < FRONT_LAT; k++) scl_q[k] <= scl_q[k-1];
    end
  end

  nmes_cordic u_cordic_x (
    .clk_i, .en_i(en), .angle_i(angle_x_i), .sin_o(data_o.sin_x), .cos_o(data_o.cos_x)
  );
  nmes_cordic u_cordic_y (
    .clk_i, .en_i(en), .angle_i(angle_y_i), .sin_o(data_o.sin_y), .cos_o(data_o.cos_y)
  );
  nmes_cordic u_cordic_z (
    .clk_i, .en_i(en), .angle_i(angle_z_i), .sin_o(data_o.sin_z), .cos_o(data_o.cos_z)
  );

  assign data_o.scl = scl_q[FRONT_LAT-1];

endmodule

### rtl/nmes_fifo.sv
// Short queue between the front and back parts.
// Depends on nmes_pkg.
module nmes_fifo
  import nmes_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sc_t      data_i,
  input  logic     pop_i,
  output sc_t      head_o,
  output fifo_st_t st_o
);

  sc_t                mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign head_o   = mem_q[rd_q];
  assign st_o.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign st_o.empty = (cnt_q == '0);

endmodule

### rtl/nmes_div.sv
// Pipelined restoring divider: rounded, saturated cofactor over determinant.
// Depends on nmes_pkg.
module nmes_div
  import nmes_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [C_W-1:0]   num_i,
  input  logic signed [DET_W-1:0] den_i,
  output logic [OUT_W-1:0]        quo_o
);

  localparam int DW = C_W + SH1;

  logic [C_W-1:0]   nmag;
  logic [DET_W-1:0] dmag;
  logic [DW-1:0]    dvd;
  logic [DET_W-1:0] rem_q [QB+1];
  logic [QB-1:0]    low_q [QB+1];
  logic [QB-1:0]    q_q   [QB+1];
  logic [DET_W-1:0] d_q   [QB+1];
  logic             neg_q [QB+1];
  logic             ovf_q [QB+1];
  logic [DET_W:0]   trial [QB];
  logic             ge    [QB];
  logic [QB-1:0]    qr, lim, mag;
  logic [OUT_W-1:0] quo_q;

  always_comb begin
    nmag = num_i[C_W-1] ? C_W'(-num_i) : C_W'(num_i);
    dmag = den_i[DET_W-1] ? DET_W'(-den_i) : DET_W'(den_i);
    dvd  = {nmag, {SH1{1'b0}}};
  end

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = {rem_q[k], low_q[k][QB-1]};
      ge[k]    = trial[k] >= {1'b0, d_q[k]};
    end
  end

  // One extra quotient bit is kept so that rounding is a plain increment.
  always_comb begin
    qr  = QB'(({1'b0, q_q[QB]} + (QB+1)'(1)) >> 1);
    lim = neg_q[QB] ? QB'(64'h8000_0000) : QB'(64'h7FFF_FFFF);
    mag = (ovf_q[QB] || qr > lim) ? lim : qr;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DET_W'(dvd[DW-1:QB]);
      low_q[0] <= dvd[QB-1:0];
      q_q[0]   <= '0;
      d_q[0]   <= dmag;
      neg_q[0] <= num_i[C_W-1] ^ den_i[DET_W-1];
      ovf_q[0] <= DET_W'(dvd[DW-1:QB]) >= dmag;
      for (int k = 0; k < QB; k++) begin
        rem_q[k+1] <= ge[k] ? DET_W'(trial[k] - {1'b0, d_q[k]}) : trial[k][DET_W-1:0];
        low_q[k+1] <= {low_q[k][QB-2:0], 1'b0};
        q_q[k+1]   <= {q_q[k][QB-2:0], ge[k]};
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
      quo_q <= neg_q[QB] ? OUT_W'(-mag) : OUT_W'(mag);
    end
  end

  assign quo_o = quo_q;

endmodule

### rtl/nmes_back.sv
// Back part: rotation, scaled model matrix, cofactors, determinant and division.
// Depends on nmes_pkg and nmes_div.
module nmes_back
  import nmes_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sc_t                   head_i,
  input  fifo_st_t              fifo_st_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [8:0][OUT_W-1:0] n_o,
  output logic                  singular_o
);

  localparam int P_W  = 2 * TRIG_W;
  localparam int MP_W = R_W + SCL_W;
  localparam int PH_W = M_W + CH_W;
  localparam int PL_W = M_W + CL_W + 1;

  logic                en;
  logic [BACK_LAT-1:0] vld_q;

  sc_t                     s0_q;
  logic signed [P_W-1:0]   pzy_q, pzsy_q, pszcx_q, pszsx_q, pszcy_q;
  logic signed [P_W-1:0]   pszsy_q, pczcx_q, pczsx_q, pcysx_q, pcycx_q;
  logic signed [TRIG_W-1:0] sx1_q, cx1_q, sy1_q;
  logic signed [SCL_W-1:0] sc1_q [3];
  logic signed [SCL_W-1:0] sc2_q [3];
  logic signed [RQ_W-1:0]  rq [3][3];
  logic signed [R_W-1:0]   r2_q [3][3];
  logic signed [MP_W-1:0]  mp [3][3];
  logic signed [M_W-1:0]   m3_q [3][3];
  logic signed [CP_W-1:0]  pa4_q [3][3];
  logic signed [CP_W-1:0]  pb4_q [3][3];
  logic signed [M_W-1:0]   m04_q [3];
  logic signed [CP_W:0]    cdiff [3][3];
  logic signed [C_W-1:0]   c5_q [3][3];
  logic signed [M_W-1:0]   m05_q [3];
  logic signed [PH_W-1:0]  ph6_q [3];
  logic signed [PL_W-1:0]  pl6_q [3];
  logic signed [C_W-1:0]   c6_q [3][3];
  logic signed [DET_W-1:0] pj7_q [3];
  logic signed [C_W-1:0]   c7_q [3][3];
  logic signed [DET_W-1:0] det8_q;
  logic signed [C_W-1:0]   c8_q [3][3];
  logic [DIV_LAT-1:0]      sing_q;
  logic [OUT_W-1:0]        quo [3][3];
  logic [8:0][OUT_W-1:0]   n_q;
  logic                    sing_out_q;

  // Every stage moves together; only a held result at the output stops it.
  assign en          = !(vld_q[BACK_LAT-1] && out_stall_i);
  assign pop_o       = en && !fifo_st_i.empty;
  assign out_valid_o = vld_q[BACK_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[BACK_LAT-2:0], pop_o};
    end
  end

  always_comb begin
    rq[0][0] = RQ_W'(pzy_q) <<< TRIG_FRAC;
    rq[0][1] = pzsy_q * sx1_q - (RQ_W'(pszcx_q) <<< TRIG_FRAC);
    rq[0][2] = pzsy_q * cx1_q + (RQ_W'(pszsx_q) <<< TRIG_FRAC);
    rq[1][0] = RQ_W'(pszcy_q) <<< TRIG_FRAC;
    rq[1][1] = pszsy_q * sx1_q + (RQ_W'(pczcx_q) <<< TRIG_FRAC);
    rq[1][2] = pszsy_q * cx1_q - (RQ_W'(pczsx_q) <<< TRIG_FRAC);
    rq[2][0] = -(RQ_W'(sy1_q) <<< (2 * TRIG_FRAC));
    rq[2][1] = RQ_W'(pcysx_q) <<< TRIG_FRAC;
    rq[2][2] = RQ_W'(pcycx_q) <<< TRIG_FRAC;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mp[i][j]    = r2_q[i][j] * sc2_q[j];
        cdiff[i][j] = (CP_W+1)'(pa4_q[i][j]) - (CP_W+1)'(pb4_q[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= head_i;

      pzy_q   <= s0_q.cos_z * s0_q.cos_y;
      pzsy_q  <= s0_q.cos_z * s0_q.sin_y;
      pszcx_q <= s0_q.sin_z * s0_q.cos_x;
      pszsx_q <= s0_q.sin_z * s0_q.sin_x;
      pszcy_q <= s0_q.sin_z * s0_q.cos_y;
      pszsy_q <= s0_q.sin_z * s0_q.sin_y;
      pczcx_q <= s0_q.cos_z * s0_q.cos_x;
      pczsx_q <= s0_q.cos_z * s0_q.sin_x;
      pcysx_q <= s0_q.cos_y * s0_q.sin_x;
      pcycx_q <= s0_q.cos_y * s0_q.cos_x;
      sx1_q   <= s0_q.sin_x;
      cx1_q   <= s0_q.cos_x;
      sy1_q   <= s0_q.sin_y;
      sc1_q[0] <= s0_q.scl.x;
      sc1_q[1] <= s0_q.scl.y;
      sc1_q[2] <= s0_q.scl.z;

      sc2_q <= sc1_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r2_q[i][j] <= R_W'((rq[i][j] + RQ_W'(1 << (2 * TRIG_FRAC - 1))) >>> (2 * TRIG_FRAC));
          m3_q[i][j] <= M_W'((mp[i][j] + MP_W'(1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC);
          pa4_q[i][j] <= m3_q[NXT1[i]][NXT1[j]] * m3_q[NXT2[i]][NXT2[j]];
          pb4_q[i][j] <= m3_q[NXT1[i]][NXT2[j]] * m3_q[NXT2[i]][NXT1[j]];
          c5_q[i][j]  <= C_W'((cdiff[i][j] + (CP_W+1)'(1 << (C_SH - 1))) >>> C_SH);
        end
      end

      m04_q <= m3_q[0];
      m05_q <= m04_q;

      // The determinant products are split on the cofactor into two halves.
      for (int j = 0; j < 3; j++) begin
        ph6_q[j] <= m05_q[j] * $signed(c5_q[0][j][C_W-1:CL_W]);
        pl6_q[j] <= m05_q[j] * $signed({1'b0, c5_q[0][j][CL_W-1:0]});
        pj7_q[j] <= (DET_W'(ph6_q[j]) <<< CL_W) + DET_W'(pl6_q[j]);
      end
      c6_q <= c5_q;
      c7_q <= c6_q;

      det8_q <= pj7_q[0] + pj7_q[1] + pj7_q[2];
      c8_q   <= c7_q;

      sing_q <= {sing_q[DIV_LAT-2:0], det8_q == '0};

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          n_q[i*3+j] <= sing_q[DIV_LAT-1] ? '0 : quo[i][j];
        end
      end
      sing_out_q <= sing_q[DIV_LAT-1];
    end
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      nmes_div u_div (
        .clk_i,
        .en_i (en),
        .num_i(c8_q[gi][gj]),
        .den_i(det8_q),
        .quo_o(quo[gi][gj])
      );
    end
  end

  assign n_o        = n_q;
  assign singular_o = sing_out_q;

endmodule

### rtl/normal_matrix_from_euler_scale_unit.sv
// Top level of the normal matrix unit: front, queue and back.
// Depends on nmes_pkg, nmes_front, nmes_fifo, nmes_back and the defines header.
//
//   channel | handshake                     | payload
//   --------+-------------------------------+-------------------------------------
//   input   | in_valid_i / in_stall_o       | angle_{x,y,z}_i, scale_{x,y,z}_i
//   output  | out_valid_o / out_stall_i     | n00_o .. n22_o, singular_o
//
// One word is taken per cycle while in_stall_o is low; the front is a fully pipelined
// CORDIC, and the back holds the matrix stages and the one-bit-per-stage dividers.
// Reset clears only the valid bits and the four-entry queue pointers and count.
// A stalled output freezes the back; the front runs on until the queue is full.
`include "normal_matrix_from_euler_scale_unit_defines.svh"

module normal_matrix_from_euler_scale_unit
  import nmes_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [ANG_W-1:0] angle_x_i,
  input  logic signed [ANG_W-1:0] angle_y_i,
  input  logic signed [ANG_W-1:0] angle_z_i,
  input  logic signed [SCL_W-1:0] scale_x_i,
  input  logic signed [SCL_W-1:0] scale_y_i,
  input  logic signed [SCL_W-1:0] scale_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] n00_o,
  output logic signed [OUT_W-1:0] n01_o,
  output logic signed [OUT_W-1:0] n02_o,
  output logic signed [OUT_W-1:0] n10_o,
  output logic signed [OUT_W-1:0] n11_o,
  output logic signed [OUT_W-1:0] n12_o,
  output logic signed [OUT_W-1:0] n20_o,
  output logic signed [OUT_W-1:0] n21_o,
  output logic signed [OUT_W-1:0] n22_o,
  output logic                    singular_o
);

  scale_t                scl;
  fifo_st_t              fifo_st;
  logic                  push, pop;
  sc_t                   front_data, head;
  logic [8:0][OUT_W-1:0] n_flat;

  assign scl.x = scale_x_i;
  assign scl.y = scale_y_i;
  assign scl.z = scale_z_i;

  nmes_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .angle_x_i,
    .angle_y_i,
    .angle_z_i,
    .scl_i    (scl),
    .fifo_st_i(fifo_st),
    .push_o   (push),
    .data_o   (front_data)
  );

  nmes_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i(push),
    .data_i(front_data),
    .pop_i (pop),
    .head_o(head),
    .st_o  (fifo_st)
  );

  nmes_back u_back (
    .clk_i,
    .rst_ni,
    .head_i    (head),
    .fifo_st_i (fifo_st),
    .pop_o     (pop),
    .out_valid_o,
    .out_stall_i,
    .n_o       (n_flat),
    .singular_o
  );

  assign n00_o = $signed(n_flat[0]);
  assign n01_o = $signed(n_flat[1]);
  assign n02_o = $signed(n_flat[2]);
  assign n10_o = $signed(n_flat[3]);
  assign n11_o = $signed(n_flat[4]);
  assign n12_o = $signed(n_flat[5]);
  assign n20_o = $signed(n_flat[6]);
  assign n21_o = $signed(n_flat[7]);
  assign n22_o = $signed(n_flat[8]);

  `NMES_ASSERT_IMPLIES(a_push_room, clk_i, rst_ni, push, !fifo_st.full)
  `NMES_ASSERT_IMPLIES(a_pop_data, clk_i, rst_ni, pop, !fifo_st.empty)
  `NMES_ASSERT_NEXT(a_queue_holds, clk_i, rst_ni, !fifo_st.empty && !pop, !fifo_st.empty)
  `NMES_ASSERT_IMPLIES(a_sing_zero, clk_i, rst_ni, out_valid_o && singular_o, n00_o == '0 && n11_o == '0 && n22_o == '0)

endmodule

### dv/normal_matrix_from_euler_scale_unit_tb.sv
// Self-checking testbench of the normal matrix unit: directed rows, then random words.
// Depends on nmes_pkg and the normal_matrix_from_euler_scale_unit RTL only.
`timescale 1ns / 1ps

module normal_matrix_from_euler_scale_unit_tb;
  import nmes_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] n [9];
    logic                    sing;
  } normal_t;

  typedef struct {
    logic signed [ANG_W-1:0] ax, ay, az;
    logic signed [SCL_W-1:0] sx, sy, sz;
    bit                      known_singular;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic signed [ANG_W-1:0] ang_x = '0, ang_y = '0, ang_z = '0;
  logic signed [SCL_W-1:0] scl_x = '0, scl_y = '0, scl_z = '0;
  logic in_stall, out_valid, singular;
  logic signed [OUT_W-1:0] n_out [9];

  normal_t pending_normals [$];
  bit      row_is_singular = 1'b0;
  int      words_taken = 0;
  int      errors = 0;
  int      stall_mode = 0;
  int      stall_cnt = 0;

  always #5 clk = ~clk;

  normal_matrix_from_euler_scale_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .angle_x_i(ang_x), .angle_y_i(ang_y), .angle_z_i(ang_z),
    .scale_x_i(scl_x), .scale_y_i(scl_y), .scale_z_i(scl_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .n00_o(n_out[0]), .n01_o(n_out[1]), .n02_o(n_out[2]),
    .n10_o(n_out[3]), .n11_o(n_out[4]), .n12_o(n_out[5]),
    .n20_o(n_out[6]), .n21_o(n_out[7]), .n22_o(n_out[8]),
    .singular_o(singular)
  );

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Folds the angle into a quarter turn either side of zero and runs the CORDIC.
  function automatic void trig_of(logic signed [ANG_W-1:0] raw, output longint s,
                                  output longint c);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = longint'(raw) % FULL_TURN;
    flip = 1'b0;
    if (a < 0) a += FULL_TURN;
    if (a > QUARTER_TURN && a <= FULL_TURN - QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1'b1;
    end else if (a > FULL_TURN - QUARTER_TURN) begin
      a -= FULL_TURN;
    end
    x = 652032874;
    y = 0;
    z = a * 1024;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    x = round_shift(x, 16);
    y = round_shift(y, 16);
    if (x > TRIG_ONE) x = TRIG_ONE;
    if (x < -TRIG_ONE) x = -TRIG_ONE;
    if (y > TRIG_ONE) y = TRIG_ONE;
    if (y < -TRIG_ONE) y = -TRIG_ONE;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [OUT_W-1:0] scaled_quotient(longint num, longint den);
    logic [127:0] nq, dq, q, r, lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    nq = 128'(num < 0 ? -num : num) << (16 + OUT_FRAC_BITS);
    dq = 128'(den < 0 ? -den : den);
    q = nq / dq;
    r = nq % dq;
    if (2 * r >= dq) q++;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -q[OUT_W-1:0] : q[OUT_W-1:0];
  endfunction

  function automatic normal_t normal_of(logic signed [ANG_W-1:0] ax, ay, az,
                                        logic signed [SCL_W-1:0] sx, sy, sz);
    longint snx, csx, sny, csy, snz, csz, det;
    longint r [3][3];
    longint m [3][3];
    longint c [3][3];
    longint sc [3];
    normal_t res;
    trig_of(ax, snx, csx);
    trig_of(ay, sny, csy);
    trig_of(az, snz, csz);
    sc[0] = sx; sc[1] = sy; sc[2] = sz;
    r[0][0] = csz * csy * 16384;
    r[0][1] = csz * sny * snx - snz * csx * 16384;
    r[0][2] = csz * sny * csx + snz * snx * 16384;
    r[1][0] = snz * csy * 16384;
    r[1][1] = snz * sny * snx + csz * csx * 16384;
    r[1][2] = snz * sny * csx - csz * snx * 16384;
    r[2][0] = -sny * 16384 * 16384;
    r[2][1] = csy * snx * 16384;
    r[2][2] = csy * csx * 16384;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = round_shift(round_shift(r[i][j], 28) * sc[j], 14);
    // Cofactor of (i, j) from the cyclic neighbours gives the signs for free.
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        c[i][j] = round_shift(m[NXT1[i]][NXT1[j]] * m[NXT2[i]][NXT2[j]]
                              - m[NXT1[i]][NXT2[j]] * m[NXT2[i]][NXT1[j]], 16);
    det = m[0][0] * c[0][0] + m[0][1] * c[0][1] + m[0][2] * c[0][2];
    for (int k = 0; k < 9; k++)
      res.n[k] = (det == 0) ? '0 : scaled_quotient(c[k / 3][k % 3], det);
    res.sing = (det == 0);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    errors++;
  endtask

  // Input words are taken and predicted at the rising edge.
  always @(posedge clk) begin
    normal_t want;
    if (in_valid && !in_stall) begin
      if (row_is_singular) begin
        foreach (want.n[k]) want.n[k] = '0;
        want.sing = 1'b1;
      end else begin
        want = normal_of(ang_x, ang_y, ang_z, scl_x, scl_y, scl_z);
      end
      pending_normals.insert(pending_normals.size(), want);
      words_taken++;
    end
    if (out_valid && !out_stall) begin
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_normals.pop_front();
        for (int k = 0; k < 9; k++)
          if (n_out[k] !== want.n[k])
            report_mismatch($sformatf("n%0d%0d", k / 3, k % 3), n_out[k], want.n[k]);
        if (singular !== want.sing) report_mismatch("singular", singular, want.sing);
      end
    end
  end

  // The receiver changes its stall behaviour at random among four modes, keyed to its cycle counter.
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_cnt % 16) < 11;
    endcase
  end

  task automatic send_word(row_t w);
    int target;
    target = words_taken + 1;
    ang_x <= w.ax; ang_y <= w.ay; ang_z <= w.az;
    scl_x <= w.sx; scl_y <= w.sy; scl_z <= w.sz;
    row_is_singular <= w.known_singular;
    in_valid <= 1'b1;
    do @(negedge clk); while (words_taken != target);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  function automatic logic signed [ANG_W-1:0] random_angle(int kind);
    int edges [6] = '{0, QUARTER_TURN, HALF_TURN, FULL_TURN - QUARTER_TURN, FULL_TURN,
                      FULL_TURN + QUARTER_TURN};
    if (kind == 3)
      return ANG_W'(($urandom_range(0, 1) ? -1 : 1) * edges[$urandom_range(0, 5)]
                    + int'($urandom_range(0, 2)) - 1);
    return ANG_W'($urandom);
  endfunction

  function automatic logic signed [SCL_W-1:0] random_scale(int kind);
    case (kind)
      1: return SCL_W'($urandom);
      2: return SCL_W'(int'($urandom_range(0, 2047)) - 1024);
      default: return SCL_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  row_t directed [] = '{
    '{16'sd0, 16'sd0, 16'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1},
    '{16'sd0, 16'sd0, 16'sd0, 24'sd65536, 24'sd65536, 24'sd65536, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, 24'sd0, 24'sd65536, 24'sd65536, 1'b1},
    '{16'sd1000, 16'sd0, 16'sd0, 24'sd65536, 24'sd65536, 24'sd0, 1'b1},
    '{16'sd0, 16'sd0, 16'sd0, 24'sd1, 24'sd1, 24'sd1, 1'b1},
    '{16'sd32767, 16'sd32767, 16'sd32767, 24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -24'sd8388608, -24'sd8388608,
      -24'sd8388608, 1'b0},
    '{16'sd5760, 16'sd5761, 16'sd11520, 24'sd65536, 24'sd131072, 24'sd32768, 1'b0},
    '{16'sd17280, 16'sd17281, 16'sd23040, 24'sd65536, 24'sd65536, 24'sd65536, 1'b0},
    '{-16'sd5760, -16'sd5761, -16'sd23040, 24'sd98304, 24'sd65536, 24'sd65536, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, 24'sd8388607, 24'sd8388607, 24'sd1, 1'b0},
    '{16'sd2880, 16'sd1440, 16'sd720, 24'sd256, 24'sd256, 24'sd256, 1'b0},
    '{16'sd2880, 16'sd1440, 16'sd720, -24'sd65536, -24'sd65536, -24'sd65536, 1'b0},
    '{16'sd1234, -16'sd4321, 16'sd8000, 24'sd300000, -24'sd70000, 24'sd12345, 1'b0},
    '{16'sd11519, 16'sd11521, -16'sd11520, 24'sd1, 24'sd8388607, -24'sd8388608, 1'b0},
    '{16'sd100, 16'sd200, 16'sd300, 24'sd65536, 24'sd65536, 24'sd65536, 1'b0}
  };

  initial begin
    row_t w;
    int kind, burst;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) begin
      send_word(directed[i]);
      idle_gap($urandom_range(0, 2));
    end
    w.known_singular = 1'b0;
    for (int sent = 0; sent < 1750; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        kind = $urandom_range(0, 3);
        w.ax = random_angle(kind); w.ay = random_angle(kind); w.az = random_angle(kind);
        w.sx = random_scale(kind); w.sy = random_scale(kind); w.sz = random_scale(kind);
        send_word(w);
        sent++;
      end
      // Now and then the sender holds off until the pipeline has fully drained.
      if ($urandom_range(0, 15) == 0) begin
        in_valid <= 1'b0;
        while (pending_normals.size() != 0) @(negedge clk);
      end else begin
        idle_gap($urandom_range(0, 12));
      end
    end
    in_valid <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("normal_matrix_from_euler_scale_unit_tb passed");
    else $display("normal_matrix_from_euler_scale_unit_tb failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("normal_matrix_from_euler_scale_unit_tb failed");
    $finish;
  end

endmodule
